FILE: design/tono_pkg.sv
package tono_pkg;

  localparam int unsigned OptionTableDepth = 256;

  // telnet command bytes
  localparam logic [7:0] T_IAC  = 8'd255;
  localparam logic [7:0] T_DONT = 8'd254;
  localparam logic [7:0] T_DO   = 8'd253;
  localparam logic [7:0] T_WONT = 8'd252;
  localparam logic [7:0] T_WILL = 8'd251;
  localparam logic [7:0] T_SB   = 8'd250;
  localparam logic [7:0] T_SE   = 8'd240;

  // option codes
  localparam logic [7:0] O_ECHO  = 8'd1;
  localparam logic [7:0] O_SGA   = 8'd3;
  localparam logic [7:0] O_TTYPE = 8'd24;
  localparam logic [7:0] O_NAWS  = 8'd31;
  localparam logic [7:0] TTYPE_SEND = 8'd1;

  localparam logic [3:0] NameMaxChars = 4'd8;

  // option answer codes held in the tables
  localparam logic [1:0] ANS_NONE   = 2'd0;
  localparam logic [1:0] ANS_ACCEPT = 2'd1;
  localparam logic [1:0] ANS_REFUSE = 2'd2;

  // configuration register indexes
  localparam logic [7:0] CFG_WINDOW_WIDTH  = 8'd0;
  localparam logic [7:0] CFG_WINDOW_HEIGHT = 8'd1;
  localparam logic [7:0] CFG_TERM_NAME     = 8'd2;
  localparam logic [7:0] CFG_TERM_NAME_LEN = 8'd3;

  localparam logic [7:0]  RstWindowWidth  = 8'd80;
  localparam logic [7:0]  RstWindowHeight = 8'd25;
  localparam logic [63:0] RstTermName     = 64'd1397708869;
  localparam logic [3:0]  RstTermNameLen  = 4'd4;

  typedef enum logic [2:0] {
    PH_DATA    = 3'd0,
    PH_IAC     = 3'd1,
    PH_VERB    = 3'd2,
    PH_SUB     = 3'd3,
    PH_SUB_IAC = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } verb_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_VERB  = 2'd2,
    ACT_TTYPE = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    JOB_DATA  = 2'd0,
    JOB_REPLY = 2'd1,
    JOB_NAWS  = 2'd2,
    JOB_TTYPE = 2'd3
  } job_e;

endpackage

FILE: design/tono_ram.sv
module tono_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/telnet_option_negotiator.sv
// A request passes through stage 1 and the emitter job register into the output register.
// The input takes one byte a cycle while no earlier results are pending; it stalls only
// while earlier results drain, one result byte a cycle while the output is taken.
// Option tables sit in one 256 x 4 RAM (read at accept, written as the request leaves stage 1).
// Reset clears per-entry valid bits at once, so every option reads as unanswered;
// configuration registers return to their defaults. No clearing pass is needed.
module telnet_option_negotiator #(
  parameter int unsigned OPTION_TABLE_DEPTH = tono_pkg::OptionTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        to_server_o,
  output logic        remote_echo_o,
  output logic        last_o
);
  import tono_pkg::*;

  localparam int unsigned OptAw = $clog2(OPTION_TABLE_DEPTH);

  // configuration
  logic [7:0]  win_w_q, win_h_q;
  logic [63:0] term_name_q;
  logic [3:0]  term_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q     <= RstWindowWidth;
      win_h_q     <= RstWindowHeight;
      term_name_q <= RstTermName;
      term_len_q  <= RstTermNameLen;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_WIDTH:  win_w_q     <= cfg_data_i[7:0];
        CFG_WINDOW_HEIGHT: win_h_q     <= cfg_data_i[7:0];
        CFG_TERM_NAME:     term_name_q <= cfg_data_i;
        CFG_TERM_NAME_LEN: term_len_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // parser state
  phase_e     phase_q, phase_d;
  verb_e      verb_q, verb_d;
  logic [7:0] sub_first_q, sub_first_d, sub_second_q, sub_second_d;
  logic [1:0] sub_cnt_q, sub_cnt_d;
  act_e       act;
  logic       rx_fire;

  // stage 1: parsed request waiting for its table entry
  logic       s1_q;
  act_e       s1_act_q;
  verb_e      s1_verb_q;
  logic [7:0] s1_b_q;
  logic       s1_adv;

  // emitter job
  logic       job_q, job_d;
  job_e       job_kind_q;
  logic [7:0] job_b_q, job_opt_q;
  logic [3:0] job_idx_q, job_end_q;
  logic       job_echo_q;
  logic       job_free, emit, emit_last;
  logic [7:0] emit_byte;

  logic       echo_q, echo_d;

  assign rx_fire    = rx_valid_i && rx_ready_o;
  assign rx_ready_o = !s1_q || s1_adv;

  // next phase
  always_comb begin
    phase_d = phase_q;
    verb_d  = verb_q;
    if (rx_fire) begin
      unique case (phase_q)
        PH_IAC: begin
          if (rx_byte_i == T_SB) begin
            phase_d = PH_SUB;
          end else if (rx_byte_i >= T_WILL && rx_byte_i <= T_DONT) begin
            phase_d = PH_VERB;
            verb_d  = verb_e'(2'(rx_byte_i - T_WILL));
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_VERB:    phase_d = PH_DATA;
        PH_SUB:     phase_d = (rx_byte_i == T_IAC) ? PH_SUB_IAC : PH_SUB;
        PH_SUB_IAC: phase_d = (rx_byte_i == T_SE) ? PH_DATA : PH_SUB;
        default:    phase_d = (rx_byte_i == T_IAC) ? PH_IAC : PH_DATA;
      endcase
    end
  end

  // parser outputs: request kind and subnegotiation capture
  always_comb begin
    act          = ACT_NONE;
    sub_first_d  = sub_first_q;
    sub_second_d = sub_second_q;
    sub_cnt_d    = sub_cnt_q;
    unique case (phase_q) inside
      PH_IAC: begin
        if (rx_byte_i == T_IAC) begin
          act = ACT_DATA;
        end else if (rx_byte_i == T_SB) begin
          sub_cnt_d = 2'd0;
        end
      end
      PH_VERB: act = ACT_VERB;
      PH_SUB, PH_SUB_IAC: begin
        if ((phase_q == PH_SUB && rx_byte_i != T_IAC) ||
            (phase_q == PH_SUB_IAC && rx_byte_i != T_SE)) begin
          if (sub_cnt_q == 2'd0) begin
            sub_first_d = rx_byte_i;
            sub_cnt_d   = 2'd1;
          end else if (sub_cnt_q == 2'd1) begin
            sub_second_d = rx_byte_i;
            sub_cnt_d    = 2'd2;
          end
        end else if (phase_q == PH_SUB_IAC && sub_cnt_q == 2'd2 &&
                     sub_first_q == O_TTYPE && sub_second_q == TTYPE_SEND) begin
          act = ACT_TTYPE;
        end
      end
      default: if (rx_byte_i != T_IAC) act = ACT_DATA;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_DATA;
      verb_q       <= VERB_WILL;
      sub_first_q  <= '0;
      sub_second_q <= '0;
      sub_cnt_q    <= '0;
    end else begin
      phase_q <= phase_d;
      verb_q  <= verb_d;
      if (rx_fire) begin
        sub_first_q  <= sub_first_d;
        sub_second_q <= sub_second_d;
        sub_cnt_q    <= sub_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else if (rx_fire) begin
      s1_q <= 1'b1;
    end else if (s1_adv) begin
      s1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      s1_act_q  <= act;
      s1_verb_q <= verb_q;
      s1_b_q    <= (phase_q == PH_IAC) ? T_IAC : rx_byte_i;
    end
  end

  // option tables: remote answer in [1:0], local answer in [3:2]
  logic                          opt_vld_q [OPTION_TABLE_DEPTH];
  logic [3:0]                    ram_rdata, entry, ram_wdata;
  logic                          ram_re, ram_we, wr_need;
  logic [1:0]                    rem_ans, loc_ans, rem_new, loc_new;
  logic [OptAw-1:0]              s1_addr;

  assign ram_re  = rx_fire && phase_q == PH_VERB;
  assign s1_addr = s1_b_q[OptAw-1:0];
  assign ram_we  = s1_adv && s1_act_q == ACT_VERB && wr_need;

  tono_ram #(
    .WIDTH(4),
    .DEPTH(OPTION_TABLE_DEPTH)
  ) u_opt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rx_byte_i[OptAw-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(OPTION_TABLE_DEPTH); i++) opt_vld_q[i] <= 1'b0;
    end else if (ram_we) begin
      opt_vld_q[s1_addr] <= 1'b1;
    end
  end

  assign entry     = opt_vld_q[s1_addr] ? ram_rdata : {ANS_NONE, ANS_NONE};
  assign rem_ans   = entry[1:0];
  assign loc_ans   = entry[3:2];
  assign ram_wdata = {loc_new, rem_new};

  // resolve stage 1 into an emitter job
  logic       res_job;
  job_e       res_kind;
  logic [7:0] res_b;
  logic [3:0] res_end, name_n;
  logic       ok;

  assign name_n = (term_len_q > NameMaxChars) ? NameMaxChars : term_len_q;

  always_comb begin
    res_job  = 1'b0;
    res_kind = JOB_DATA;
    res_b    = s1_b_q;
    res_end  = 4'd0;
    wr_need  = 1'b0;
    rem_new  = rem_ans;
    loc_new  = loc_ans;
    echo_d   = echo_q;
    ok       = 1'b0;
    unique case (s1_act_q)
      ACT_DATA: res_job = 1'b1;
      ACT_TTYPE: begin
        res_job  = 1'b1;
        res_kind = JOB_TTYPE;
        res_end  = 4'd5 + name_n;
      end
      ACT_VERB: begin
        res_kind = JOB_REPLY;
        res_end  = 4'd2;
        unique case (s1_verb_q)
          VERB_WILL: begin
            ok      = s1_b_q == O_ECHO || s1_b_q == O_SGA;
            rem_new = ok ? ANS_ACCEPT : ANS_REFUSE;
            wr_need = rem_ans != rem_new;
            res_b   = ok ? T_DO : T_DONT;
            if (wr_need && ok && s1_b_q == O_ECHO) echo_d = 1'b1;
          end
          VERB_WONT: begin
            rem_new = ANS_REFUSE;
            wr_need = rem_ans != ANS_REFUSE;
            res_b   = T_DONT;
            if (wr_need && s1_b_q == O_ECHO) echo_d = 1'b0;
          end
          VERB_DO: begin
            ok      = s1_b_q == O_SGA || s1_b_q == O_TTYPE || s1_b_q == O_NAWS;
            loc_new = ok ? ANS_ACCEPT : ANS_REFUSE;
            wr_need = loc_ans != loc_new;
            res_b   = ok ? T_WILL : T_WONT;
            if (ok && s1_b_q == O_NAWS) begin
              res_kind = JOB_NAWS;
              res_end  = 4'd11;
            end
          end
          default: begin
            loc_new = ANS_REFUSE;
            wr_need = loc_ans != ANS_REFUSE;
            res_b   = T_WONT;
          end
        endcase
        res_job = wr_need;
      end
      default: ;
    endcase
  end

  assign job_free = !job_q || (emit && emit_last);
  assign s1_adv   = s1_q && job_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q <= 1'b0;
    end else if (s1_adv) begin
      echo_q <= echo_d;
    end
  end

  // emitter: one result byte a cycle into the output register, while that register is free or being taken
  assign emit      = job_q && (!out_valid_o || out_ready_i);
  assign emit_last = job_idx_q == job_end_q;

  logic [2:0] name_idx;
  assign name_idx = 3'(job_idx_q - 4'd4);

  always_comb begin
    emit_byte = T_SE;
    case (job_kind_q)
      JOB_DATA: emit_byte = job_b_q;
      JOB_REPLY: begin
        case (job_idx_q)
          4'd0:    emit_byte = T_IAC;
          4'd1:    emit_byte = job_b_q;
          default: emit_byte = job_opt_q;
        endcase
      end
      JOB_NAWS: begin
        case (job_idx_q)
          4'd0:    emit_byte = T_IAC;
          4'd1:    emit_byte = T_WILL;
          4'd2:    emit_byte = O_NAWS;
          4'd3:    emit_byte = T_IAC;
          4'd4:    emit_byte = T_SB;
          4'd5:    emit_byte = O_NAWS;
          4'd6:    emit_byte = 8'd0;
          4'd7:    emit_byte = win_w_q;
          4'd8:    emit_byte = 8'd0;
          4'd9:    emit_byte = win_h_q;
          4'd10:   emit_byte = T_IAC;
          default: emit_byte = T_SE;
        endcase
      end
      default: begin
        if (job_idx_q == 4'd0) begin
          emit_byte = T_IAC;
        end else if (job_idx_q == 4'd1) begin
          emit_byte = T_SB;
        end else if (job_idx_q == 4'd2) begin
          emit_byte = O_TTYPE;
        end else if (job_idx_q == 4'd3) begin
          emit_byte = 8'd0;
        end else if (job_idx_q < 4'd4 + name_n) begin
          emit_byte = term_name_q[8*name_idx +: 8];
        end else if (job_idx_q == 4'd4 + name_n) begin
          emit_byte = T_IAC;
        end else begin
          emit_byte = T_SE;
        end
      end
    endcase
  end

  always_comb begin
    job_d = job_q;
    if (s1_adv && res_job) begin
      job_d = 1'b1;
    end else if (emit && emit_last) begin
      job_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q <= 1'b0;
    end else begin
      job_q <= job_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_job) begin
      job_kind_q <= res_kind;
      job_b_q    <= res_b;
      job_opt_q  <= s1_b_q;
      job_end_q  <= res_end;
      job_idx_q  <= 4'd0;
      job_echo_q <= echo_d;
    end else if (emit) begin
      job_idx_q <= job_idx_q + 4'd1;
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_o    <= emit_byte;
      to_server_o   <= job_kind_q != JOB_DATA;
      remote_echo_o <= job_echo_q;
      last_o        <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: tb/telnet_reply_checker.sv
`timescale 1ns / 1ps
module telnet_reply_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        to_server_i,
  input  logic        remote_echo_i,
  input  logic        last_i,
  output int          mismatch_count_o,
  output int          expected_left_o
);
  import tono_pkg::*;

  localparam logic TO_DISPLAY = 1'b0;
  localparam logic TO_SERVER  = 1'b1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       to_server;
    logic       remote_echo;
    logic       is_last;
  } reply_t;

  reply_t      reply_q[$];
  logic [7:0]  step_bytes[$];
  logic        step_dest[$];

  phase_e      phase;
  verb_e       verb;
  logic [1:0]  remote_ans [OptionTableDepth];
  logic [1:0]  local_ans [OptionTableDepth];
  logic        echo_on;
  logic [7:0]  sub_first;
  logic [7:0]  sub_second;
  logic [1:0]  sub_count;
  logic [7:0]  win_w;
  logic [7:0]  win_h;
  logic [63:0] term_name;
  logic [3:0]  term_len;
  int          mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic emit(input logic [7:0] b, input logic dest);
    step_bytes.push_back(b);
    step_dest.push_back(dest);
  endtask

  task automatic emit_answer(input logic [7:0] verb_byte, input logic [7:0] opt);
    emit(T_IAC, TO_SERVER);
    emit(verb_byte, TO_SERVER);
    emit(opt, TO_SERVER);
  endtask

  task automatic sub_store(input logic [7:0] c);
    if (sub_count == 2'd0) begin
      sub_first = c;
      sub_count = 2'd1;
    end else if (sub_count == 2'd1) begin
      sub_second = c;
      sub_count = 2'd2;
    end
  endtask

  task automatic predict_replies(input logic [7:0] c);
    logic       ok;
    logic [1:0] want;
    logic [3:0] n;
    reply_t     r;
    step_bytes.delete();
    step_dest.delete();
    case (phase)
      PH_IAC: begin
        phase = PH_DATA;
        case (c)
          T_IAC: emit(T_IAC, TO_DISPLAY);
          T_SB: begin
            phase = PH_SUB;
            sub_count = 2'd0;
          end
          T_WILL: begin
            verb = VERB_WILL;
            phase = PH_VERB;
          end
          T_WONT: begin
            verb = VERB_WONT;
            phase = PH_VERB;
          end
          T_DO: begin
            verb = VERB_DO;
            phase = PH_VERB;
          end
          T_DONT: begin
            verb = VERB_DONT;
            phase = PH_VERB;
          end
          default: ;
        endcase
      end
      PH_VERB: begin
        phase = PH_DATA;
        case (verb)
          VERB_WILL: begin
            ok = (c == O_ECHO) || (c == O_SGA);
            want = ok ? ANS_ACCEPT : ANS_REFUSE;
            if (remote_ans[c] != want) begin
              remote_ans[c] = want;
              emit_answer(ok ? T_DO : T_DONT, c);
              if (ok && c == O_ECHO) echo_on = 1'b1;
            end
          end
          VERB_WONT: begin
            if (remote_ans[c] != ANS_REFUSE) begin
              remote_ans[c] = ANS_REFUSE;
              emit_answer(T_DONT, c);
              if (c == O_ECHO) echo_on = 1'b0;
            end
          end
          VERB_DO: begin
            ok = (c == O_SGA) || (c == O_TTYPE) || (c == O_NAWS);
            want = ok ? ANS_ACCEPT : ANS_REFUSE;
            if (local_ans[c] != want) begin
              local_ans[c] = want;
              emit_answer(ok ? T_WILL : T_WONT, c);
              // agreeing to window size reporting sends the size straight away
              if (ok && c == O_NAWS) begin
                emit(T_IAC, TO_SERVER);
                emit(T_SB, TO_SERVER);
                emit(O_NAWS, TO_SERVER);
                emit(8'd0, TO_SERVER);
                emit(win_w, TO_SERVER);
                emit(8'd0, TO_SERVER);
                emit(win_h, TO_SERVER);
                emit(T_IAC, TO_SERVER);
                emit(T_SE, TO_SERVER);
              end
            end
          end
          default: begin
            if (local_ans[c] != ANS_REFUSE) begin
              local_ans[c] = ANS_REFUSE;
              emit_answer(T_WONT, c);
            end
          end
        endcase
      end
      PH_SUB: begin
        if (c == T_IAC) phase = PH_SUB_IAC;
        else sub_store(c);
      end
      PH_SUB_IAC: begin
        if (c == T_SE) begin
          phase = PH_DATA;
          if (sub_count == 2'd2 && sub_first == O_TTYPE && sub_second == TTYPE_SEND) begin
            n = (term_len > NameMaxChars) ? NameMaxChars : term_len;
            emit(T_IAC, TO_SERVER);
            emit(T_SB, TO_SERVER);
            emit(O_TTYPE, TO_SERVER);
            emit(8'd0, TO_SERVER);
            for (int i = 0; i < n; i++) emit(term_name[8*i +: 8], TO_SERVER);
            emit(T_IAC, TO_SERVER);
            emit(T_SE, TO_SERVER);
          end
        end else begin
          // escaped byte inside the subnegotiation counts as payload
          sub_store(c);
          phase = PH_SUB;
        end
      end
      default: begin
        if (c == T_IAC) phase = PH_IAC;
        else emit(c, TO_DISPLAY);
      end
    endcase
    foreach (step_bytes[k]) begin
      r.out_byte    = step_bytes[k];
      r.to_server   = step_dest[k];
      r.remote_echo = echo_on;
      r.is_last     = (k == step_bytes.size() - 1);
      reply_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t got;
    reply_t want_r;
    if (!rst_ni) begin
      phase      = PH_DATA;
      verb       = VERB_WILL;
      echo_on    = 1'b0;
      sub_first  = 8'd0;
      sub_second = 8'd0;
      sub_count  = 2'd0;
      win_w      = RstWindowWidth;
      win_h      = RstWindowHeight;
      term_name  = RstTermName;
      term_len   = RstTermNameLen;
      for (int i = 0; i < OptionTableDepth; i++) begin
        remote_ans[i] = ANS_NONE;
        local_ans[i]  = ANS_NONE;
      end
      reply_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WINDOW_WIDTH:  win_w = cfg_data_i[7:0];
          CFG_WINDOW_HEIGHT: win_h = cfg_data_i[7:0];
          CFG_TERM_NAME:     term_name = cfg_data_i;
          CFG_TERM_NAME_LEN: term_len = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.out_byte    = out_byte_i;
        got.to_server   = to_server_i;
        got.remote_echo = remote_echo_i;
        got.is_last     = last_i;
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte=%h srv=%b echo=%b last=%b",
                                    got.out_byte, got.to_server, got.remote_echo,
                                    got.is_last));
        end else begin
          want_r = reply_q.pop_front();
          if (got !== want_r)
            report_mismatch($sformatf(
                "byte=%h srv=%b echo=%b last=%b, want byte=%h srv=%b echo=%b last=%b",
                got.out_byte, got.to_server, got.remote_echo, got.is_last,
                want_r.out_byte, want_r.to_server, want_r.remote_echo, want_r.is_last));
        end
      end
      if (rx_valid_i && rx_ready_i) predict_replies(rx_byte_i);
    end
    mismatch_count_o <= mismatches;
    expected_left_o  <= reply_q.size();
  end

endmodule

FILE: tb/telnet_option_negotiator_tb.sv
`timescale 1ns / 1ps
module telnet_option_negotiator_tb;
  import tono_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongHoldOff  = 160;
  localparam int unsigned PhaseBytes   = 52;
  localparam logic [7:0]  CFG_UNUSED   = 8'd9;
  localparam logic [7:0]  T_NOP        = 8'd241;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        rx_valid;
  logic        rx_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        to_server;
  logic        remote_echo;
  logic        out_last;
  int          mismatch_count;
  int          expected_left;
  int unsigned cycle_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned results_taken = 0;
  int unsigned cfg_writes    = 0;
  bit          no_gaps       = 1'b0;
  bit          hold_off_req  = 1'b0;

  telnet_option_negotiator u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .rx_valid_i    (rx_valid),
    .rx_ready_o    (rx_ready),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_byte_o    (out_byte),
    .to_server_o   (to_server),
    .remote_echo_o (remote_echo),
    .last_o        (out_last)
  );

  telnet_reply_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .rx_valid_i       (rx_valid),
    .rx_ready_i       (rx_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_byte_i       (out_byte),
    .to_server_i      (to_server),
    .remote_echo_i    (remote_echo),
    .last_i           (out_last),
    .mismatch_count_o (mismatch_count),
    .expected_left_o  (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_command(input logic [7:0] verb_byte, input logic [7:0] opt);
    send_byte(T_IAC);
    send_byte(verb_byte);
    send_byte(opt);
  endtask

  task automatic send_subneg();
    int         count;
    logic [7:0] b;
    bit         well_formed;
    well_formed = ($urandom_range(0, 9) < 6);
    count = well_formed ? $urandom_range(2, 3) : $urandom_range(0, 4);
    send_byte(T_IAC);
    send_byte(T_SB);
    for (int i = 0; i < count; i++) begin
      if (well_formed && i == 0) b = O_TTYPE;
      else if (well_formed && i == 1) b = TTYPE_SEND;
      else b = 8'($urandom_range(0, 255));
      // escape now and then, and always for a data 255
      if (b == T_IAC || (b != T_SE && $urandom_range(0, 7) == 0)) send_byte(T_IAC);
      send_byte(b);
    end
    // occasionally drop the IAC so the subnegotiation stays open
    if ($urandom_range(0, 19) != 0) send_byte(T_IAC);
    send_byte(T_SE);
  endtask

  task automatic send_random_unit();
    int         pick;
    logic [7:0] opt;
    logic [7:0] verb_byte;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_byte(8'($urandom_range(0, 254)));
    end else if (pick < 38) begin
      send_byte(T_IAC);
      send_byte(T_IAC);
    end else if (pick < 75) begin
      case ($urandom_range(0, 4))
        0: opt = O_ECHO;
        1: opt = O_SGA;
        2: opt = O_TTYPE;
        3: opt = O_NAWS;
        default: opt = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
        0: verb_byte = T_WILL;
        1: verb_byte = T_WONT;
        2: verb_byte = T_DO;
        default: verb_byte = T_DONT;
      endcase
      send_command(verb_byte, opt);
    end else if (pick < 90) begin
      send_subneg();
    end else if (pick < 95) begin
      send_byte(T_IAC);
      send_byte(8'($urandom_range(0, 249)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < count) send_random_unit();
  endtask

  task automatic drain_results();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    // let requests that give no result clear the pipeline
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  initial begin : receiver
    int stall;
    bit held_off;
    held_off = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !held_off) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (LongHoldOff) @(posedge clk);
      end
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = 8'd0;
    cfg_data  = 64'd0;
    rx_valid  = 1'b0;
    rx_byte   = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at reset settings
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(T_IAC);
    send_byte(T_IAC);
    send_command(T_WILL, O_ECHO);
    send_command(T_DO, O_NAWS);
    send_byte(T_IAC);
    send_byte(T_SB);
    send_byte(O_TTYPE);
    send_byte(TTYPE_SEND);
    send_byte(T_IAC);
    send_byte(T_SE);
    send_command(T_WONT, O_ECHO);
    send_command(T_DONT, 8'd5);
    send_byte(T_IAC);
    send_byte(T_NOP);
    run_random(40);
    drain_results();

    // top of every range, so reply bytes of 255 go out unescaped
    write_reg(CFG_WINDOW_WIDTH, 64'd255);
    write_reg(CFG_WINDOW_HEIGHT, 64'd255);
    write_reg(CFG_TERM_NAME, '1);
    write_reg(CFG_TERM_NAME_LEN, 64'd8);
    write_reg(CFG_UNUSED, '1);
    run_random(PhaseBytes);
    drain_results();

    // bottom of every range, empty terminal name
    write_reg(CFG_WINDOW_WIDTH, 64'd1);
    write_reg(CFG_WINDOW_HEIGHT, 64'd1);
    write_reg(CFG_TERM_NAME, 64'd0);
    write_reg(CFG_TERM_NAME_LEN, 64'd0);
    run_random(PhaseBytes);
    drain_results();

    // oversize name length, with the receiver held off to back the block up
    write_reg(CFG_WINDOW_WIDTH, 64'($urandom_range(1, 255)));
    write_reg(CFG_WINDOW_HEIGHT, 64'($urandom_range(1, 255)));
    write_reg(CFG_TERM_NAME, {$urandom, $urandom});
    write_reg(CFG_TERM_NAME_LEN, 64'd15);
    hold_off_req = 1'b1;
    run_random(PhaseBytes);
    drain_results();

    write_reg(CFG_TERM_NAME, {$urandom, $urandom});
    write_reg(CFG_TERM_NAME_LEN, 64'($urandom_range(1, 8)));
    no_gaps = 1'b1;
    run_random(25);
    no_gaps = 1'b0;
    drain_results();
    run_random(25);
    drain_results();

    $display("Run covered %0d stream bytes, %0d result bytes and %0d register writes,",
             bytes_sent, results_taken, cfg_writes);
    $display("across default, extreme and random settings with one long output hold-off.");
    if (mismatch_count == 0 && expected_left == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/tono_pkg.sv
design/tono_ram.sv
design/telnet_option_negotiator.sv
tb/telnet_reply_checker.sv
tb/telnet_option_negotiator_tb.sv
